// ===== rtl/core/ctc_gd_pkg.sv =====
// Package for the CTC greedy decoder: field widths, register indexes and the
// step record that travels from the front part to the back part.
// No dependencies.
package ctc_gd_pkg;

  localparam int SCORE_W    = 16;
  localparam int LABEL_W    = 13;
  localparam int MEAN_W     = 15;
  localparam int COUNT_W    = 11;
  localparam int SUM_W      = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int NCLS_W     = 14;
  localparam int NSTEP_W    = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int RST_NUM_CLASSES = 8192;
  localparam int RST_NUM_STEPS   = 80;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS   = 2'd1;

  localparam logic KIND_LABEL = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // One record per finished time step that produces any result.
  typedef struct packed {
    logic               has_label;
    logic               is_end;
    logic [LABEL_W-1:0] label_index;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } step_rec_t;

endpackage

// ===== rtl/core/ctc_gd_if.sv =====
// Channel interfaces of the CTC greedy decoder: score input, result output
// and configuration write. Depends on ctc_gd_pkg.
interface ctc_gd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ctc_gd_pkg::SCORE_W-1:0] class_score;

  modport source (output valid, output class_score, input ready);
  modport sink   (input valid, input class_score, output ready);
endinterface

interface ctc_gd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [ctc_gd_pkg::LABEL_W-1:0]  label_index;
  logic [ctc_gd_pkg::MEAN_W-1:0]   mean_score;
  logic [ctc_gd_pkg::COUNT_W-1:0]  label_count;
  logic                            last;

  modport source (output valid, output kind, output label_index, output mean_score,
                  output label_count, output last, input ready);
  modport sink   (input valid, input kind, input label_index, input mean_score,
                  input label_count, input last, output ready);
endinterface

interface ctc_gd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ctc_gd_pkg::CFG_IDX_W-1:0]  index;
  logic [ctc_gd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ctc_greedy_decoder_unit.sv =====
// Top level of the CTC greedy decoder: front part, step queue and back part.
// Depends on ctc_gd_pkg, ctc_gd_if, ctc_gd_front, ctc_gd_fifo, ctc_gd_back.
//
//   Channel    Dir  Payload                                        Handshake
//   in_chan    in   class_score (s16, Q1.15)                       valid/ready
//   out_chan   out  kind, label_index, mean_score, label_count, last  valid/ready
//   cfg_chan   in   index (0 num_classes, 1 num_steps), data        valid/ready
//
// The front part takes one score per cycle whenever the four-entry step queue
// has room. A label result is loaded into the output register when the back
// part takes its record from the queue; the final result waits for the
// bit-serial divider and then for a free output slot.
// Reset is synchronous and active low; there is no clearing pass. cfg_chan is
// always ready, and a stalled out_chan backs up into the queue and then in_chan.
module ctc_greedy_decoder_unit #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  ctc_gd_in_if.sink     in_chan,
  ctc_gd_cfg_if.sink    cfg_chan,
  ctc_gd_out_if.source  out_chan
);

  logic                  q_full, q_push, q_empty, q_pop;
  ctc_gd_pkg::step_rec_t q_in_rec, q_head_rec;

  ctc_gd_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_in_rec)
  );

  ctc_gd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_in_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (q_head_rec)
  );

  ctc_gd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rec    (q_head_rec),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/core/ctc_gd_front.sv =====
// Front part of the CTC greedy decoder: holds the configuration, tracks the
// running best class of each step and pushes one record per step that yields
// results. Depends on ctc_gd_pkg and ctc_gd_if.
module ctc_gd_front #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ctc_gd_in_if.sink              in_chan,
  ctc_gd_cfg_if.sink             cfg_chan,
  input  logic                   q_full,
  output logic                   q_push,
  output ctc_gd_pkg::step_rec_t  q_rec
);

  localparam int CPW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int SPW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int RST_LAST_CLASS =
    ((ctc_gd_pkg::RST_NUM_CLASSES > MAX_CLASSES) ? MAX_CLASSES
                                                 : ctc_gd_pkg::RST_NUM_CLASSES) - 1;
  localparam int RST_LAST_STEP =
    ((ctc_gd_pkg::RST_NUM_STEPS > MAX_STEPS) ? MAX_STEPS
                                             : ctc_gd_pkg::RST_NUM_STEPS) - 1;

  logic [CPW-1:0]                       last_class_r, last_class_nxt;
  logic [SPW-1:0]                       last_step_r, last_step_nxt;
  logic [CPW-1:0]                       class_pos_r, class_pos_nxt;
  logic [SPW-1:0]                       step_pos_r, step_pos_nxt;
  logic signed [ctc_gd_pkg::SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [CPW-1:0]                       best_idx_r, best_idx_nxt;
  logic                                 best_found_r, best_found_nxt;
  logic [CPW-1:0]                       prev_idx_r, prev_idx_nxt;
  logic                                 prev_found_r, prev_found_nxt;
  logic [ctc_gd_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic [ctc_gd_pkg::COUNT_W-1:0]       count_r, count_nxt;

  logic [ctc_gd_pkg::NCLS_W-1:0]        cfg_ncls;
  logic [ctc_gd_pkg::NSTEP_W-1:0]       cfg_nstep;
  logic                                 cfg_we, accept;
  logic                                 upd, class_end, step_end, repeat_cls, emit;
  logic signed [ctc_gd_pkg::SCORE_W-1:0] cur_score;
  logic [CPW-1:0]                       cur_idx;
  logic                                 cur_found;
  logic [ctc_gd_pkg::SUM_W-1:0]         step_sum;
  logic [ctc_gd_pkg::COUNT_W-1:0]       step_count;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_full;
  assign accept         = in_chan.valid && !q_full;
  assign cfg_we         = cfg_chan.valid &&
                          (cfg_chan.index == ctc_gd_pkg::REG_NUM_CLASSES ||
                           cfg_chan.index == ctc_gd_pkg::REG_NUM_STEPS);
  assign cfg_ncls       = cfg_chan.data[ctc_gd_pkg::NCLS_W-1:0];
  assign cfg_nstep      = cfg_chan.data[ctc_gd_pkg::NSTEP_W-1:0];

  // Registers hold the clamped count minus one, so the end test is an equality.
  always_comb begin
    last_class_nxt = last_class_r;
    last_step_nxt  = last_step_r;
    if (cfg_chan.valid && cfg_chan.index == ctc_gd_pkg::REG_NUM_CLASSES) begin
      if (cfg_ncls == '0) begin
        last_class_nxt = '0;
      end else if (32'(cfg_ncls) > MAX_CLASSES) begin
        last_class_nxt = CPW'(MAX_CLASSES - 1);
      end else begin
        last_class_nxt = CPW'(cfg_ncls - 1'b1);
      end
    end
    if (cfg_chan.valid && cfg_chan.index == ctc_gd_pkg::REG_NUM_STEPS) begin
      if (cfg_nstep == '0) begin
        last_step_nxt = '0;
      end else if (32'(cfg_nstep) > MAX_STEPS) begin
        last_step_nxt = SPW'(MAX_STEPS - 1);
      end else begin
        last_step_nxt = SPW'(cfg_nstep - 1'b1);
      end
    end
  end

  assign upd        = in_chan.class_score > best_score_r;
  assign cur_score  = upd ? in_chan.class_score : best_score_r;
  assign cur_idx    = upd ? class_pos_r : best_idx_r;
  assign cur_found  = upd || best_found_r;
  assign class_end  = class_pos_r == last_class_r;
  assign step_end   = step_pos_r == last_step_r;
  assign repeat_cls = (step_pos_r != '0) && prev_found_r && (prev_idx_r == cur_idx);
  assign emit       = cur_found && (cur_idx != '0) && !repeat_cls;
  // A found best is always positive, so its low 15 bits are its value.
  assign step_sum   = emit ? sum_r + ctc_gd_pkg::SUM_W'(cur_score[ctc_gd_pkg::SCORE_W-2:0])
                           : sum_r;
  assign step_count = emit ? count_r + 1'b1 : count_r;

  assign q_push            = accept && class_end && (emit || step_end);
  assign q_rec.has_label   = emit;
  assign q_rec.is_end      = step_end;
  assign q_rec.label_index = ctc_gd_pkg::LABEL_W'(cur_idx);
  assign q_rec.count       = step_count;
  assign q_rec.sum         = step_sum;

  always_comb begin
    class_pos_nxt  = class_pos_r;
    step_pos_nxt   = step_pos_r;
    best_score_nxt = best_score_r;
    best_idx_nxt   = best_idx_r;
    best_found_nxt = best_found_r;
    prev_idx_nxt   = prev_idx_r;
    prev_found_nxt = prev_found_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    if (cfg_we) begin
      class_pos_nxt  = '0;
      step_pos_nxt   = '0;
      best_score_nxt = '0;
      best_idx_nxt   = '0;
      best_found_nxt = 1'b0;
      prev_idx_nxt   = '0;
      prev_found_nxt = 1'b0;
      sum_nxt        = '0;
      count_nxt      = '0;
    end else if (accept) begin
      if (!class_end) begin
        class_pos_nxt  = class_pos_r + 1'b1;
        best_score_nxt = cur_score;
        best_idx_nxt   = cur_idx;
        best_found_nxt = cur_found;
      end else begin
        class_pos_nxt  = '0;
        best_score_nxt = '0;
        best_idx_nxt   = '0;
        best_found_nxt = 1'b0;
        if (!step_end) begin
          step_pos_nxt   = step_pos_r + 1'b1;
          prev_idx_nxt   = cur_idx;
          prev_found_nxt = cur_found;
          sum_nxt        = step_sum;
          count_nxt      = step_count;
        end else begin
          step_pos_nxt   = '0;
          prev_idx_nxt   = '0;
          prev_found_nxt = 1'b0;
          sum_nxt        = '0;
          count_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_class_r <= CPW'(RST_LAST_CLASS);
      last_step_r  <= SPW'(RST_LAST_STEP);
      class_pos_r  <= '0;
      step_pos_r   <= '0;
      best_score_r <= '0;
      best_idx_r   <= '0;
      best_found_r <= 1'b0;
      prev_idx_r   <= '0;
      prev_found_r <= 1'b0;
      sum_r        <= '0;
      count_r      <= '0;
    end else begin
      last_class_r <= last_class_nxt;
      last_step_r  <= last_step_nxt;
      class_pos_r  <= class_pos_nxt;
      step_pos_r   <= step_pos_nxt;
      best_score_r <= best_score_nxt;
      best_idx_r   <= best_idx_nxt;
      best_found_r <= best_found_nxt;
      prev_idx_r   <= prev_idx_nxt;
      prev_found_r <= prev_found_nxt;
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/ctc_gd_fifo.sv =====
// Short queue of step records between the front and back parts of the CTC
// greedy decoder. Depends on ctc_gd_pkg.
module ctc_gd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ctc_gd_pkg::step_rec_t push_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output ctc_gd_pkg::step_rec_t head_rec
);

  ctc_gd_pkg::step_rec_t              mem [ctc_gd_pkg::QUEUE_DEPTH];
  logic [ctc_gd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ctc_gd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ctc_gd_pkg::QCNT_W-1:0]      fill_r, fill_nxt;

  assign full     = fill_r == ctc_gd_pkg::QCNT_W'(ctc_gd_pkg::QUEUE_DEPTH);
  assign empty    = fill_r == '0;
  assign head_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/ctc_gd_back.sv =====
// Back part of the CTC greedy decoder: turns step records into label and
// final results, with a bit-serial divider for the mean score.
// Depends on ctc_gd_pkg and ctc_gd_if.
module ctc_gd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  ctc_gd_pkg::step_rec_t q_rec,
  output logic                  q_pop,
  ctc_gd_out_if.source          out_chan
);

  localparam int DIV_CNT_W = $clog2(ctc_gd_pkg::SUM_W);
  localparam int COUNT_W   = ctc_gd_pkg::COUNT_W;
  localparam int SUM_W     = ctc_gd_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } back_state_t;

  back_state_t                    state_r, state_nxt;
  logic [COUNT_W:0]               rem_r, rem_nxt;
  logic [SUM_W-1:0]               quo_r, quo_nxt;
  logic [COUNT_W-1:0]             den_r, den_nxt;
  logic [DIV_CNT_W-1:0]           div_cnt_r, div_cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_kind_r, out_kind_nxt;
  logic [ctc_gd_pkg::LABEL_W-1:0] out_label_r, out_label_nxt;
  logic [ctc_gd_pkg::MEAN_W-1:0]  out_mean_r, out_mean_nxt;
  logic [COUNT_W-1:0]             out_count_r, out_count_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           slot_free, take;
  logic [COUNT_W:0]               rem_sh;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign take      = (state_r == S_IDLE) && !q_empty && (!q_rec.has_label || slot_free);
  assign q_pop     = take;
  assign rem_sh    = {rem_r[COUNT_W-1:0], quo_r[SUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_label_nxt = out_label_r;
    out_mean_nxt  = out_mean_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (q_rec.has_label) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ctc_gd_pkg::KIND_LABEL;
            out_label_nxt = q_rec.label_index;
            out_mean_nxt  = '0;
            out_count_nxt = q_rec.count;
            out_last_nxt  = 1'b0;
          end
          if (q_rec.is_end) begin
            rem_nxt     = '0;
            quo_nxt     = q_rec.sum;
            den_nxt     = q_rec.count;
            div_cnt_nxt = '0;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        if (div_cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          state_nxt = S_FIN;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ctc_gd_pkg::KIND_FINAL;
          out_label_nxt = '0;
          // With nothing emitted the mean is zero, not the divider's all-ones.
          out_mean_nxt  = (den_r == '0) ? '0 : quo_r[ctc_gd_pkg::MEAN_W-1:0];
          out_count_nxt = den_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    den_r       <= den_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_label_r <= out_label_nxt;
    out_mean_r  <= out_mean_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.label_index = out_label_r;
  assign out_chan.mean_score  = out_mean_r;
  assign out_chan.label_count = out_count_r;
  assign out_chan.last        = out_last_r;

endmodule

// ===== tb/ctc_gd_checker.sv =====
// Checker for the CTC greedy decoder: watches the score, result and register
// channels, predicts each result and compares it field by field.
// Depends on ctc_gd_pkg and the channel interfaces in ctc_gd_if.
module ctc_gd_checker #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  ctc_gd_in_if    in_chan,
  ctc_gd_cfg_if   cfg_chan,
  ctc_gd_out_if   out_chan,
  output int      errors,
  output int      pending,
  output int      labels_seen,
  output int      finals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCORE_W = ctc_gd_pkg::SCORE_W;
  localparam int LABEL_W = ctc_gd_pkg::LABEL_W;
  localparam int MEAN_W  = ctc_gd_pkg::MEAN_W;
  localparam int COUNT_W = ctc_gd_pkg::COUNT_W;
  localparam int SUM_W   = ctc_gd_pkg::SUM_W;
  localparam int NCLS_W  = ctc_gd_pkg::NCLS_W;
  localparam int NSTEP_W = ctc_gd_pkg::NSTEP_W;

  typedef struct packed {
    logic               kind;
    logic [LABEL_W-1:0] label_index;
    logic [MEAN_W-1:0]  mean_score;
    logic [COUNT_W-1:0] label_count;
    logic               last;
  } decode_result_t;

  logic [NCLS_W-1:0]  num_classes_reg;
  logic [NSTEP_W-1:0] num_steps_reg;

  int unsigned        class_pos;
  int unsigned        step_pos;
  int                 best_score;
  logic [LABEL_W-1:0] best_idx;
  bit                 best_found;
  logic [LABEL_W-1:0] prev_idx;
  bit                 prev_found;
  logic [SUM_W-1:0]   score_sum;
  int unsigned        label_total;

  decode_result_t     expected_results[$];

  initial begin
    errors      = 0;
    pending     = 0;
    labels_seen = 0;
    finals_seen = 0;
  end

  function void clear_sequence();
    class_pos   = 0;
    step_pos    = 0;
    best_score  = 0;
    best_idx    = '0;
    best_found  = 0;
    prev_idx    = '0;
    prev_found  = 0;
    score_sum   = '0;
    label_total = 0;
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Folds one score into the running best of the step and queues the label
  // and final results that it completes.
  task greedy_decode_score(input logic signed [SCORE_W-1:0] score);
    int unsigned    classes;
    int unsigned    steps;
    int             value;
    bit             is_repeat;
    decode_result_t r;
    classes = (num_classes_reg == 0) ? 1 :
              (num_classes_reg > MAX_CLASSES) ? MAX_CLASSES : num_classes_reg;
    steps   = (num_steps_reg == 0) ? 1 :
              (num_steps_reg > MAX_STEPS) ? MAX_STEPS : num_steps_reg;
    value   = score;
    if (value > best_score) begin
      best_score = value;
      best_idx   = class_pos[LABEL_W-1:0];
      best_found = 1;
    end
    if (class_pos + 1 < classes) begin
      class_pos++;
      return;
    end
    // The first step of a sequence and a step after one with no class are
    // never repeats.
    is_repeat = step_pos > 0 && prev_found && prev_idx == best_idx;
    if (best_found && best_idx != 0 && !is_repeat) begin
      score_sum = score_sum + SUM_W'(best_score);
      label_total++;
      r.kind        = ctc_gd_pkg::KIND_LABEL;
      r.label_index = best_idx;
      r.mean_score  = '0;
      r.label_count = label_total[COUNT_W-1:0];
      r.last        = 1'b0;
      expected_results = {expected_results, r};
    end
    prev_idx   = best_idx;
    prev_found = best_found;
    best_score = 0;
    best_idx   = '0;
    best_found = 0;
    class_pos  = 0;
    if (step_pos + 1 < steps) begin
      step_pos++;
      return;
    end
    r.kind        = ctc_gd_pkg::KIND_FINAL;
    r.label_index = '0;
    r.mean_score  = (label_total != 0) ? MEAN_W'(score_sum / label_total) : '0;
    r.label_count = label_total[COUNT_W-1:0];
    r.last        = 1'b1;
    expected_results = {expected_results, r};
    clear_sequence();
  endtask

  always @(posedge clk) begin
    decode_result_t want;
    if (!rst_n) begin
      num_classes_reg = NCLS_W'(ctc_gd_pkg::RST_NUM_CLASSES);
      num_steps_reg   = NSTEP_W'(ctc_gd_pkg::RST_NUM_STEPS);
      clear_sequence();
      expected_results.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %0d label %0d mean %0d",
                   $time, out_chan.kind, out_chan.label_index, out_chan.mean_score);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_chan.kind);
          check_field("label_index", want.label_index, out_chan.label_index);
          check_field("mean_score", want.mean_score, out_chan.mean_score);
          check_field("label_count", want.label_count, out_chan.label_count);
          check_field("last", want.last, out_chan.last);
        end
        if (out_chan.kind == ctc_gd_pkg::KIND_FINAL) begin
          finals_seen++;
        end else begin
          labels_seen++;
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        // A write to either register abandons the sequence in progress.
        case (cfg_chan.index)
          ctc_gd_pkg::REG_NUM_CLASSES: begin
            num_classes_reg = cfg_chan.data[NCLS_W-1:0];
            clear_sequence();
          end
          ctc_gd_pkg::REG_NUM_STEPS: begin
            num_steps_reg = cfg_chan.data[NSTEP_W-1:0];
            clear_sequence();
          end
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        greedy_decode_score(in_chan.class_score);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_ctc_greedy_decoder_unit.sv =====
// Testbench top for the CTC greedy decoder: clock, reset, register writes,
// score stimulus, result backpressure, watchdog and verdict.
// Depends on ctc_gd_pkg, ctc_gd_if, ctc_greedy_decoder_unit and ctc_gd_checker.
module tb_ctc_greedy_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_CLASSES  = 8192;
  localparam int MAX_STEPS    = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SCORE_W      = ctc_gd_pkg::SCORE_W;
  localparam int CFG_IDX_W    = ctc_gd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = ctc_gd_pkg::CFG_DATA_W;

  typedef enum int {ROW_RANDOM, ROW_NEGATIVE, ROW_REPEAT, ROW_PLANTED} row_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  ctc_gd_in_if  in_chan();
  ctc_gd_cfg_if cfg_chan();
  ctc_gd_out_if out_chan();

  int errors;
  int pending;
  int labels_seen;
  int finals_seen;

  int unsigned eff_classes = ctc_gd_pkg::RST_NUM_CLASSES;
  int unsigned eff_steps   = ctc_gd_pkg::RST_NUM_STEPS;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 0;
  int scores_sent    = 0;
  int reg_writes     = 0;
  int quiet_cycles   = 0;
  logic signed [SCORE_W-1:0] last_row[$];

  ctc_greedy_decoder_unit #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg_chan(cfg_chan),
    .out_chan(out_chan)
  );

  ctc_gd_checker #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .out_chan   (out_chan),
    .errors     (errors),
    .pending    (pending),
    .labels_seen(labels_seen),
    .finals_seen(finals_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still expected",
               $time, quiet_cycles, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Waits until the block is idle, then writes one register.
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    int unsigned field;
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // A step that produced no result may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    reg_writes++;
    case (idx)
      ctc_gd_pkg::REG_NUM_CLASSES: begin
        field = value & 32'h3FFF;
        eff_classes = (field == 0) ? 1 : (field > MAX_CLASSES) ? MAX_CLASSES : field;
      end
      ctc_gd_pkg::REG_NUM_STEPS: begin
        field = value & 32'h7FF;
        eff_steps = (field == 0) ? 1 : (field > MAX_STEPS) ? MAX_STEPS : field;
      end
      default: ;
    endcase
  endtask

  task send_score(input logic signed [SCORE_W-1:0] score);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.class_score <= score;
    do @(posedge clk); while (!in_chan.ready);
    scores_sent++;
  endtask

  // Mix of full-range noise, values near zero, extremes and coarse positive
  // values that tie often.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom();
      3, 4:    v = int'($urandom_range(8)) - 4;
      5: begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(8, 1)) * 4096 - 1;
    endcase
    return v[SCORE_W-1:0];
  endfunction

  task send_step(input row_kind_t kind, input int unsigned winner);
    int v;
    logic signed [SCORE_W-1:0] s;
    logic signed [SCORE_W-1:0] row[$];
    if (kind == ROW_REPEAT && last_row.size() != eff_classes) begin
      kind = ROW_RANDOM;
    end
    for (int unsigned i = 0; i < eff_classes; i++) begin
      case (kind)
        ROW_NEGATIVE: begin
          v = -int'($urandom_range(32768));
          s = v[SCORE_W-1:0];
        end
        ROW_REPEAT: s = last_row[i];
        ROW_PLANTED: begin
          s = rand_score();
          if (i == winner) begin
            s = 16'sh7FFF;
          end else if (s == 16'sh7FFF) begin
            s = 16'sh7FFE;
          end
        end
        default: s = rand_score();
      endcase
      row = {row, s};
      send_score(s);
    end
    last_row = row;
  endtask

  task send_sequence();
    for (int unsigned st = 0; st < eff_steps; st++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_step(ROW_RANDOM, 0);
        4:          send_step(ROW_NEGATIVE, 0);
        5, 6:       send_step(ROW_REPEAT, 0);
        default:    send_step(ROW_PLANTED, $urandom_range(eff_classes - 1));
      endcase
    end
  endtask

  task random_config();
    case ($urandom_range(19))
      0:                  write_reg(ctc_gd_pkg::REG_NUM_CLASSES, $urandom_range(1));
      14, 15, 16, 17, 18: write_reg(ctc_gd_pkg::REG_NUM_CLASSES, $urandom_range(24, 6));
      19:                 write_reg(ctc_gd_pkg::REG_NUM_CLASSES, $urandom_range(40, 25));
      default:            write_reg(ctc_gd_pkg::REG_NUM_CLASSES, $urandom_range(5, 2));
    endcase
    case ($urandom_range(19))
      0:              write_reg(ctc_gd_pkg::REG_NUM_STEPS, 0);
      16, 17, 18, 19: write_reg(ctc_gd_pkg::REG_NUM_STEPS, $urandom_range(12, 7));
      default:        write_reg(ctc_gd_pkg::REG_NUM_STEPS, $urandom_range(6, 1));
    endcase
  endtask

  task run_phase(input int idle_pct, input int stall_pct, input int n_scores,
                 input bit with_hold);
    int start;
    bit must_write;
    int unsigned cut;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start      = scores_sent;
    must_write = 1;
    while (scores_sent - start < n_scores) begin
      if (must_write || $urandom_range(3) == 0) begin
        random_config();
        must_write = 0;
      end
      if (with_hold) begin
        hold_req  = 1;
        with_hold = 0;
      end
      if (eff_classes * eff_steps > 1 && $urandom_range(9) == 0) begin
        // Break off in the middle; the next register write aborts it.
        cut = $urandom_range(eff_classes * eff_steps - 1, 1);
        repeat (cut) send_score(rand_score());
        must_write = 1;
      end else begin
        send_sequence();
      end
    end
  endtask

  initial begin
    in_chan.valid       <= 1'b0;
    in_chan.class_score <= '0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= ctc_gd_pkg::REG_NUM_CLASSES;
    cfg_chan.data       <= '0;
    rst_n               <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 3);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 3);
    // Two equal maxima: the first one wins. Then the same class again, which
    // is a repeat, then a step where nothing is above zero.
    send_score(16'sh8000); send_score(16'sh7FFF); send_score(16'sh7FFF);
    send_score(16'sh0000); send_score(16'sh7FFF); send_score(16'sh0005);
    send_score(16'shFFFF); send_score(16'shFFFF); send_score(16'shFFFF);

    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 2);
    // Blank wins, no class, then class 1 with the smallest positive score.
    send_score(16'sd5); send_score(16'sd3);
    send_score(16'sd0); send_score(16'sd0);
    send_score(16'sd0); send_score(16'sd1);
    // The same class on both sides of a step without a class is emitted twice.
    send_score(16'sd0); send_score(16'sd7);
    send_score(16'sd0); send_score(16'sd0);
    send_score(16'sd0); send_score(16'sd9);

    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 4);
    send_score(16'sd0); send_score(16'sd7); send_score(16'sd0);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 1);
    // Nothing emitted: the mean is zero.
    send_score(16'sd100); send_score(-16'sd5);

    // Alternating classes: every step emits a label.
    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 3);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 20);
    for (int unsigned st = 0; st < 20; st++) send_step(ROW_PLANTED, st % 2 + 1);

    // Oversized counts act as the maximum; the next write breaks this one off.
    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 16383);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 2047);
    repeat (30) send_score(rand_score());

    // Zero classes act as one, and so do zero steps.
    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 0);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 5);
    send_sequence();
    write_reg(ctc_gd_pkg::REG_NUM_CLASSES, 1);
    write_reg(ctc_gd_pkg::REG_NUM_STEPS, 0);
    send_sequence();

    run_phase(0, 0, 250, 1);
    run_phase(74, 0, 250, 0);
    run_phase(0, 74, 250, 0);
    run_phase(11, 11, 250, 0);

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d scores under %0d register writes, with stalls on both sides.",
             scores_sent, reg_writes);
    $display("Checked %0d label results and %0d sequence results.", labels_seen, finals_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
